// ===== hw/rtl/clustered_hash_table_age_replace_assert.svh =====
// Assertion macros shared by the hash table checker.
`ifndef CLUSTERED_HASH_TABLE_AGE_REPLACE_ASSERT_SVH
`define CLUSTERED_HASH_TABLE_AGE_REPLACE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hash table check failed");

// Next-cycle implication, disabled while reset is low.
`define CHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hash table check failed");

`endif

// ===== hw/rtl/cht_pkg.sv =====
// Types, constants and codes shared by the clustered hash table modules.
package cht_pkg;

  // Table geometry.
  localparam int INDEX_BITS = 12;
  localparam int WAYS       = 4;
  localparam int AGE_MAX    = 7;
  localparam int CLUSTERS   = 1 << INDEX_BITS;
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W      = $clog2(AGE_MAX + 1);

  // Field widths.
  localparam int OP_W      = 2;
  localparam int KEY_W     = 64;
  localparam int TAG_W     = 16;
  localparam int TAG_SHIFT = 48;
  localparam int DEPTH_W   = 7;
  localparam int BOUND_W   = 2;
  localparam int PAYLOAD_W = 32;
  localparam int CFG_W     = 4;

  // Replacement score is depth minus age gap, kept signed.
  localparam int SCORE_W     = DEPTH_W + AGE_W + 1;
  localparam int WEAK_MARGIN = 3;

  localparam logic [CFG_W-1:0]   IDX_BITS_RESET = 4'd12;
  localparam logic [BOUND_W-1:0] BOUND_EXACT    = 2'd3;

  // Operation codes; code 3 is ignored.
  typedef enum logic [OP_W-1:0] {
    OP_PROBE  = 2'd0,
    OP_INSERT = 2'd1,
    OP_AGE    = 2'd2
  } op_e;

  // One stored entry.
  typedef struct packed {
    logic [TAG_W-1:0]     tag;
    logic [AGE_W-1:0]     age;
    logic [DEPTH_W-1:0]   depth;
    logic [BOUND_W-1:0]   bound;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One cluster row holds all ways.
  typedef entry_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  // Way selection result handed to the control logic.
  typedef struct packed {
    logic             hit;
    entry_t           found;
    logic [WAY_W-1:0] way;
    logic             write;
  } sel_t;

endpackage

// ===== hw/rtl/cht_row_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module cht_row_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 240
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int Depth = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_q [Depth];
  logic [DATA_W-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cht_select.sv =====
// Parallel way compare: probe hit, replacement target and weak-update check.
module cht_select import cht_pkg::*; (
  input  row_t               row_i,
  input  logic [TAG_W-1:0]   tag_i,
  input  logic [AGE_W-1:0]   age_i,
  input  logic [DEPTH_W-1:0] depth_i,
  input  logic [BOUND_W-1:0] bound_i,
  output sel_t               sel_o
);

  logic signed [SCORE_W-1:0] score [WAYS];
  logic signed [SCORE_W-1:0] best_score;
  logic [WAY_W-1:0]          best_way;
  logic [WAY_W-1:0]          tag_way;
  logic [WAY_W-1:0]          hit_way;
  logic [WAY_W-1:0]          tgt_way;
  logic                      tag_any;
  logic                      hit_any;
  logic                      weak_upd;
  entry_t                    tgt;

  // Score of each way: stored depth minus how many ages ago it was written.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      score[w] = SCORE_W'(row_i[w].depth) + SCORE_W'(row_i[w].age) - SCORE_W'(age_i);
    end
  end

  // First way with a matching tag, and first way with matching tag and age.
  always_comb begin
    tag_any = 1'b0;
    tag_way = '0;
    hit_any = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_i[w].tag == tag_i) begin
        tag_any = 1'b1;
        tag_way = WAY_W'(w);
        if (row_i[w].age == age_i) begin
          hit_any = 1'b1;
          hit_way = WAY_W'(w);
        end
      end
    end
  end

  // Lowest score wins; on a tie the later way wins.
  always_comb begin
    best_way   = '0;
    best_score = score[0];
    for (int w = 1; w < WAYS; w++) begin
      if (best_score >= score[w]) begin
        best_way   = WAY_W'(w);
        best_score = score[w];
      end
    end
  end

  // Target way and the weak-update filter.
  always_comb begin
    tgt_way  = tag_any ? tag_way : best_way;
    tgt      = row_i[tgt_way];
    weak_upd = tag_any && (bound_i != BOUND_EXACT) &&
               (({1'b0, depth_i} + (DEPTH_W + 1)'(WEAK_MARGIN)) < {1'b0, tgt.depth});
  end

  assign sel_o.hit   = hit_any;
  assign sel_o.found = hit_any ? row_i[hit_way] : '0;
  assign sel_o.way   = tgt_way;
  assign sel_o.write = !weak_upd;

endmodule

// ===== hw/rtl/clustered_hash_table_age_replace.sv =====
// Clustered hash table with depth and age replacement, top level.
//
//   Port group     Direction  Handshake          Content
//   request        in         start / busy       operation, hash key, entry fields
//   result         out        done_o strobe      hit and found entry fields
//   configuration  in         cfg_we_i           index bits in use
//
// For every accepted request the cluster row is read from the row RAM, then
// compared in the lookup state, where an insert writes it back.
// A probe result shows on done_o for one cycle, the cycle after the compare.
// After reset, and after an age advance at the maximum age, a clearing sweep
// zeroes the RAM one row a cycle with busy high.
// The receiver cannot stall; configuration writes are taken in any cycle.
module clustered_hash_table_age_replace import cht_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [KEY_W-1:0]     hash_key_i,
  input  logic [DEPTH_W-1:0]   entry_depth_i,
  input  logic [BOUND_W-1:0]   entry_bound_i,
  input  logic [PAYLOAD_W-1:0] entry_payload_i,
  output logic                 done_o,
  output logic                 hit_o,
  output logic [DEPTH_W-1:0]   found_depth_o,
  output logic [BOUND_W-1:0]   found_bound_o,
  output logic [PAYLOAD_W-1:0] found_payload_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CLEAR
  } state_e;

  state_e                  state_q;
  logic [CFG_W-1:0]        idx_bits_q;
  logic [AGE_W-1:0]        age_q;
  logic [INDEX_BITS-1:0]   clr_q;
  logic [OP_W-1:0]         op_q;
  logic [TAG_W-1:0]        tag_q;
  logic [INDEX_BITS-1:0]   idx_q;
  logic [DEPTH_W-1:0]      depth_q;
  logic [BOUND_W-1:0]      bound_q;
  logic [PAYLOAD_W-1:0]    payload_q;
  logic                    done_q;
  logic                    hit_q;
  logic [DEPTH_W-1:0]      fdepth_q;
  logic [BOUND_W-1:0]      fbound_q;
  logic [PAYLOAD_W-1:0]    fpayload_q;

  logic                    accept;
  logic [INDEX_BITS-1:0]   idx_mask;
  logic [INDEX_BITS-1:0]   idx_d;
  logic [ROW_W-1:0]        rdata;
  row_t                    row;
  row_t                    new_row;
  entry_t                  new_entry;
  sel_t                    sel;
  logic                    ram_we;
  logic [INDEX_BITS-1:0]   ram_waddr;
  logic [ROW_W-1:0]        ram_wdata;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Cluster index: low key bits masked by the configured width.
  always_comb begin
    for (int i = 0; i < INDEX_BITS; i++) begin
      idx_mask[i] = (int'(idx_bits_q) > i);
    end
    idx_d = hash_key_i[INDEX_BITS-1:0] & idx_mask;
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_bits_q <= IDX_BITS_RESET;
    end else if (cfg_we_i) begin
      idx_bits_q <= cfg_data_i;
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= operation_i;
      tag_q     <= hash_key_i[TAG_SHIFT +: TAG_W];
      idx_q     <= idx_d;
      depth_q   <= entry_depth_i;
      bound_q   <= entry_bound_i;
      payload_q <= entry_payload_i;
    end
  end

  // Row storage: read on accept, written back during the lookup cycle, zeroed by the sweep.
  cht_row_ram #(
    .ADDR_W (INDEX_BITS),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (idx_d),
    .rdata_o (rdata)
  );

  assign row = row_t'(rdata);

  cht_select u_select (
    .row_i   (row),
    .tag_i   (tag_q),
    .age_i   (age_q),
    .depth_i (depth_q),
    .bound_i (bound_q),
    .sel_o   (sel)
  );

  // Modified row with the new entry in the target way.
  always_comb begin
    new_entry.tag     = tag_q;
    new_entry.age     = age_q;
    new_entry.depth   = depth_q;
    new_entry.bound   = bound_q;
    new_entry.payload = payload_q;
    new_row           = row;
    new_row[sel.way]  = new_entry;
  end

  // Write port: clearing sweep or insert write-back.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = ROW_W'(new_row);
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (state_q == ST_LOOKUP && op_q == OP_INSERT && sel.write) begin
      ram_we = 1'b1;
    end
  end

  // Control state, search age and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      age_q      <= '0;
      done_q     <= 1'b0;
      hit_q      <= 1'b0;
      fdepth_q   <= '0;
      fbound_q   <= '0;
      fpayload_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state_q <= ST_IDLE;
          unique case (op_q)
            OP_PROBE: begin
              done_q     <= 1'b1;
              hit_q      <= sel.hit;
              fdepth_q   <= sel.found.depth;
              fbound_q   <= sel.found.bound;
              fpayload_q <= sel.found.payload;
            end
            OP_AGE: begin
              if (age_q >= AGE_W'(AGE_MAX)) begin
                age_q   <= '0;
                clr_q   <= '0;
                state_q <= ST_CLEAR;
              end else begin
                age_q <= age_q + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == INDEX_BITS'(CLUSTERS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign found_depth_o   = fdepth_q;
  assign found_bound_o   = fbound_q;
  assign found_payload_o = fpayload_q;

endmodule

// ===== hw/rtl/cht_checker.sv =====
// Port-level checker for the clustered hash table, bound to the top level.
`include "clustered_hash_table_age_replace_assert.svh"

module cht_checker import cht_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic [OP_W-1:0]      operation_i,
  input logic                 done_o,
  input logic                 hit_o,
  input logic [DEPTH_W-1:0]   found_depth_o,
  input logic [BOUND_W-1:0]   found_bound_o,
  input logic [PAYLOAD_W-1:0] found_payload_o
);

  logic acc;
  logic acc_probe;
  logic miss_zero;

  assign acc       = start && !busy;
  assign acc_probe = acc && (operation_i == OP_PROBE);
  assign miss_zero = (found_depth_o == '0) && (found_bound_o == '0) &&
                     (found_payload_o == '0);

  // Every result comes from an accepted probe, via the lookup state and result register.
  `CHT_ASSERT_IMP(a_done_from_probe, clk_i, rst_ni, done_o, $past(acc_probe, 2))

  // Every accepted probe yields a result, via the lookup state and result register.
  `CHT_ASSERT_IMP(a_probe_gives_done, clk_i, rst_ni, $past(acc_probe, 2), done_o)

  // A miss reports zero entry fields.
  `CHT_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, done_o && !hit_o, miss_zero)

  // An accepted request keeps the block busy for its compare cycle.
  `CHT_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, acc, busy)

endmodule

bind clustered_hash_table_age_replace cht_checker u_cht_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .operation_i     (operation_i),
  .done_o          (done_o),
  .hit_o           (hit_o),
  .found_depth_o   (found_depth_o),
  .found_bound_o   (found_bound_o),
  .found_payload_o (found_payload_o)
);
